[rtl/fdnm_pkg.sv]
// ----------------------------------------------------------------------------
// fdnm_pkg
// shared types, constants and helpers for the directory name match block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdnm_pkg;

    localparam int ENTRIES_PER_SECTOR = 16;
    localparam int ENTRY_BYTES        = 32;
    localparam int SECTOR_BYTES       = ENTRIES_PER_SECTOR * ENTRY_BYTES;
    localparam int POS_W              = $clog2(SECTOR_BYTES);
    localparam int OFF_W              = 9;
    localparam int TGT_CHARS          = 12;

    // configuration register indexes
    localparam logic [1:0] CFG_NAME_LOW    = 2'd0;
    localparam logic [1:0] CFG_NAME_HIGH   = 2'd1;
    localparam logic [1:0] CFG_NAME_LENGTH = 2'd2;

    // byte codes
    localparam logic [7:0] CH_DELETED  = 8'he5;
    localparam logic [7:0] CH_ESC_E5   = 8'h05;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOT      = 8'h2e;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5a;
    localparam logic [7:0] CH_CASE_BIT = 8'h20;

    // byte places within an entry
    localparam logic [4:0] J_FIRST    = 5'h00;
    localparam logic [4:0] J_EXT      = 5'h08;
    localparam logic [4:0] J_NAME_END = 5'h0b;
    localparam logic [4:0] J_ATTR     = 5'h0b;
    localparam logic [4:0] J_CLUS_LO  = 5'h1a;
    localparam logic [4:0] J_CLUS_HI  = 5'h1b;
    localparam logic [4:0] J_SIZE_0   = 5'h1c;
    localparam logic [4:0] J_SIZE_1   = 5'h1d;
    localparam logic [4:0] J_SIZE_2   = 5'h1e;
    localparam logic [4:0] J_LAST     = 5'h1f;

    localparam int ATTR_VOL_BIT = 3;
    localparam int ATTR_DIR_BIT = 4;

    typedef logic [15:0][7:0] t_name_chars;

    typedef struct packed {
        t_name_chars chars;
        logic [3:0]  len;
    } t_target;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_req;

    typedef struct packed {
        logic             matched;
        logic [OFF_W-1:0] entry_offset;
        logic             is_directory;
        logic [15:0]      first_cluster;
        logic [31:0]      file_size;
    } t_result;

    // true when character ch at place k of the formed name breaks the match
    function automatic logic char_miss(t_target tgt, logic [3:0] k, logic [7:0] ch);
        logic miss;
        miss = (k >= tgt.len) || (k >= 4'(TGT_CHARS)) || (tgt.chars[k] != ch);
        return miss;
    endfunction

    function automatic logic [3:0] len_inc(logic [3:0] k);
        logic [3:0] res;
        res = (k == 4'hf) ? k : k + 4'd1;
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/fat_directory_name_match_core.sv]
// ----------------------------------------------------------------------------
// fat_directory_name_match_core
// scans directory sector bytes and reports one name match result per entry
// ----------------------------------------------------------------------------
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+----------------------------------
// byte in   | in        | i_valid / o_ready  | i_data_byte, i_restart
// result    | out       | o_valid / i_ready  | o_matched, o_entry_offset,
//           |           |                    | o_is_directory, o_first_cluster,
//           |           |                    | o_file_size
// config    | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// one byte request per cycle while o_ready is high; byte 31 of an entry shows its result
// after acceptance through the input register, then the result register
// synchronous active-low reset clears the position counter and the valid bits of both registers
// a stalled result holds the result register; bytes keep flowing until a
// second result needs the register, then o_ready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fat_directory_name_match_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [7:0]                 i_data_byte,
    input  wire                        i_restart,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic                       o_matched,
    output logic [fdnm_pkg::OFF_W-1:0] o_entry_offset,
    output logic                       o_is_directory,
    output logic [15:0]                o_first_cluster,
    output logic [31:0]                o_file_size,
    input  wire                        i_cfg_we,
    input  wire  [1:0]                 i_cfg_index,
    input  wire  [63:0]                i_cfg_data
);
    import fdnm_pkg::*;

    logic [63:0] r_tgt_low;
    logic [31:0] r_tgt_high;
    logic [3:0]  r_tgt_len;

    t_target target;
    t_req    in_req;
    t_req    stage_req;
    t_result scan_result;
    t_result out_result;
    logic    stage_valid;
    logic    out_free;
    logic    step;
    logic    produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_low  <= 64'd0;
            r_tgt_high <= 32'd0;
            r_tgt_len  <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NAME_LOW:    r_tgt_low  <= i_cfg_data;
                CFG_NAME_HIGH:   r_tgt_high <= i_cfg_data[31:0];
                CFG_NAME_LENGTH: r_tgt_len  <= i_cfg_data[3:0];
                default:         r_tgt_len  <= r_tgt_len;
            endcase
        end
    end

    assign target.chars     = t_name_chars'({32'd0, r_tgt_high, r_tgt_low});
    assign target.len       = r_tgt_len;
    assign in_req.data_byte = i_data_byte;
    assign in_req.restart   = i_restart;
    assign step             = stage_valid && (out_free || !produce);

    fdnm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (in_req),
        .o_valid (stage_valid),
        .i_take  (step),
        .o_req   (stage_req)
    );

    fdnm_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_req     (stage_req),
        .i_target  (target),
        .o_produce (produce),
        .o_result  (scan_result)
    );

    fdnm_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (step),
        .i_produce (produce),
        .i_result  (scan_result),
        .o_free    (out_free),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (out_result)
    );

    assign o_matched       = out_result.matched;
    assign o_entry_offset  = out_result.entry_offset;
    assign o_is_directory  = out_result.is_directory;
    assign o_first_cluster = out_result.first_cluster;
    assign o_file_size     = out_result.file_size;

endmodule

`default_nettype wire

[rtl/fdnm_in_reg.sv]
// ----------------------------------------------------------------------------
// fdnm_in_reg
// input register holding one sector byte request until the scan stage takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdnm_in_reg (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  fdnm_pkg::t_req    i_req,
    output logic              o_valid,
    input  wire               i_take,
    output fdnm_pkg::t_req    o_req
);
    import fdnm_pkg::*;

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

`default_nettype wire

[rtl/fdnm_scan.sv]
// ----------------------------------------------------------------------------
// fdnm_scan
// per-byte entry scan: position count, 8.3 name forming and compare, field capture
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdnm_scan (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_step,
    input  fdnm_pkg::t_req     i_req,
    input  fdnm_pkg::t_target  i_target,
    output logic               o_produce,
    output fdnm_pkg::t_result  o_result
);
    import fdnm_pkg::*;

    logic [POS_W-1:0] r_pos,  n_pos;
    logic [3:0]       r_flen, n_flen;
    logic             r_miss, n_miss;
    logic             r_ended, n_ended;
    logic             r_in_use, n_in_use;
    logic [7:0]       r_attr, n_attr;
    logic [7:0]       r_clus_lo, n_clus_lo;
    logic [15:0]      r_clus, n_clus;
    logic [23:0]      r_size, n_size;

    logic [POS_W-1:0]       pos_eff;
    logic [POS_W:0]         pos_inc;
    logic [POS_W+OFF_W-1:0] pos_ext;
    logic [4:0]             j;
    logic [7:0]             b;
    logic [7:0]             ch;
    logic [7:0]             ch_esc;
    logic                   first;
    logic [3:0]             flen0;
    logic [3:0]             flen1;
    logic                   miss0;
    logic                   ended0;
    logic                   is_ext;
    logic                   is_dir;

    always_comb begin
        b       = i_req.data_byte;
        pos_eff = i_req.restart ? '0 : r_pos;
        pos_inc = {1'b0, pos_eff} + 1'b1;
        n_pos   = (pos_inc == (POS_W+1)'(SECTOR_BYTES)) ? '0 : pos_inc[POS_W-1:0];
        j       = pos_eff[4:0];
        first   = (j == J_FIRST);

        ch_esc = (b == CH_ESC_E5) ? CH_DELETED : b;
        ch     = (ch_esc >= CH_UPPER_A && ch_esc <= CH_UPPER_Z) ?
                 (ch_esc | CH_CASE_BIT) : ch_esc;
        is_ext = (j == J_EXT);

        // name state as seen by this byte
        flen0  = first ? 4'd0 : r_flen;
        miss0  = first ? 1'b0 : r_miss;
        ended0 = first ? 1'b0 : r_ended;

        n_flen   = flen0;
        n_miss   = miss0;
        n_ended  = ended0;
        n_in_use = first ? (b != CH_NUL && b != CH_DELETED) : r_in_use;
        flen1    = flen0;

        if (j < J_NAME_END && !ended0 && ch != CH_SPACE) begin
            if (is_ext) begin
                n_miss = n_miss | char_miss(i_target, flen0, CH_DOT);
                flen1  = len_inc(flen0);
            end
            if (ch == CH_NUL) begin
                n_ended = 1'b1;
                n_flen  = flen1;
            end else begin
                n_miss = n_miss | char_miss(i_target, flen1, ch);
                n_flen = len_inc(flen1);
            end
        end

        n_attr    = r_attr;
        n_clus_lo = r_clus_lo;
        n_clus    = r_clus;
        n_size    = r_size;
        unique case (j)
            J_ATTR:    n_attr    = b;
            J_CLUS_LO: n_clus_lo = b;
            J_CLUS_HI: n_clus    = {b, r_clus_lo};
            J_SIZE_0:  n_size    = {16'd0, b};
            J_SIZE_1:  n_size    = {8'd0, b, r_size[7:0]};
            J_SIZE_2:  n_size    = {b, r_size[15:0]};
            default:   n_size    = r_size;
        endcase

        // result for the entry closing with this byte
        is_dir                 = r_attr[ATTR_DIR_BIT];
        pos_ext                = {{OFF_W{1'b0}}, pos_eff};
        o_produce              = (j == J_LAST);
        o_result.matched       = r_in_use && !r_attr[ATTR_VOL_BIT] && !r_miss &&
                                 (r_flen == i_target.len);
        o_result.entry_offset  = {pos_ext[OFF_W-1:5], 5'd0};
        o_result.is_directory  = is_dir;
        o_result.first_cluster = (is_dir && r_clus == 16'd0) ? 16'd1 : r_clus;
        o_result.file_size     = {b, r_size};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_flen    <= 4'd0;
            r_miss    <= 1'b0;
            r_ended   <= 1'b0;
            r_in_use  <= 1'b0;
            r_attr    <= 8'd0;
            r_clus_lo <= 8'd0;
            r_clus    <= 16'd0;
            r_size    <= 24'd0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_flen    <= n_flen;
            r_miss    <= n_miss;
            r_ended   <= n_ended;
            r_in_use  <= n_in_use;
            r_attr    <= n_attr;
            r_clus_lo <= n_clus_lo;
            r_clus    <= n_clus;
            r_size    <= n_size;
        end
    end

endmodule

`default_nettype wire

[rtl/fdnm_out_reg.sv]
// ----------------------------------------------------------------------------
// fdnm_out_reg
// result register holding one entry result until the consumer takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdnm_out_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  wire                i_produce,
    input  fdnm_pkg::t_result  i_result,
    output logic               o_free,
    output logic               o_valid,
    input  wire                i_ready,
    output fdnm_pkg::t_result  o_result
);
    import fdnm_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && i_produce) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_produce) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

[rtl/fdnm_checker.sv]
// ----------------------------------------------------------------------------
// fdnm_checker
// port-level checks on the result channel of the directory name match block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdnm_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        o_valid,
    input wire                        i_ready,
    input wire [fdnm_pkg::OFF_W-1:0]  o_entry_offset,
    input wire                        o_is_directory,
    input wire [15:0]                 o_first_cluster,
    input wire [31:0]                 o_file_size
);
    import fdnm_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_file_size) &&
                                $stable(o_entry_offset))
        else $error("stalled result changed");

    // offsets fall on entry boundaries
    a_offset_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_offset[4:0] == 5'd0)
        else $error("entry offset not aligned");

    // directories never report cluster zero
    a_dir_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_directory |-> o_first_cluster != 16'd0)
        else $error("directory with cluster zero");

endmodule

bind fat_directory_name_match_core fdnm_checker u_fdnm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_entry_offset  (o_entry_offset),
    .o_is_directory  (o_is_directory),
    .o_first_cluster (o_first_cluster),
    .o_file_size     (o_file_size)
);

`default_nettype wire
